### rtl/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multi-level priority queue
// Request and response layouts, opcodes, status codes and store sizing.
// ----------------------------------------------------------------------------
package mlpq_pkg;

   localparam int NUM_PRIORITIES = 8;
   localparam int QUEUE_DEPTH    = 64;
   // stored data width, at most the 32-bit payload field
   localparam int DATA_WIDTH     = 32;

   localparam int LEVEL_W = 3;
   localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_W = 7;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_FRONT  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_PURGE  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(NUM_PRIORITIES - 1);

   typedef struct packed {
      logic [1:0]         opcode;
      logic [LEVEL_W-1:0] level;
      logic [31:0]        payload;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        read_payload;
      logic [LEVEL_W-1:0] read_level;
      logic [COUNT_W-1:0] purged_count;
   } rsp_type;

   // command from the control path to the slot array
   typedef struct packed {
      logic                  insert;
      logic                  front;
      logic                  pop;
      logic                  clear;
      logic [LEVEL_W-1:0]    level;
      logic [DATA_WIDTH-1:0] data;
   } slot_cmd_type;

   // head slot of the array
   typedef struct packed {
      logic                  valid;
      logic [LEVEL_W-1:0]    level;
      logic [DATA_WIDTH-1:0] data;
   } slot_head_type;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lv);
      logic [LEVEL_W-1:0] res;
      res = lv;
      if (lv > MAX_LEVEL) begin
         res = MAX_LEVEL;
      end
      return res;
   endfunction

endpackage

### rtl/multi_level_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// multi_level_priority_queue_unit: bounded multi-level priority queue
// Append, insert-front, read-up-to-level and purge on an ordered slot store.
// ----------------------------------------------------------------------------
// Usage: drive req_item and pulse start; the request is taken at a rising
// edge with start high and busy low. busy stays low, so one request can be
// taken in every cycle. Each request yields exactly one response: rsp_valid
// is high for one cycle with rsp_item once the request has passed the
// request register, which feeds the slot compare/shift, and then the
// response register. Throughput is one request per cycle; the slot array
// updates in the same cycle the response is formed, so back to back
// requests see each other's effect in order.
// Reads return status empty when the head entry is less urgent than the
// requested level; writes into a full store return status full and drop
// the entry. Purge reports how many entries were discarded.
// Synchronous reset empties the store and drops any request in flight.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module multi_level_priority_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mlpq_pkg::req_type req_item,
   output logic              rsp_valid,
   output mlpq_pkg::rsp_type rsp_item
);

   logic                       req_valid_ff;
   mlpq_pkg::req_type          req_ff;
   logic [mlpq_pkg::OCC_W-1:0] occupancy_ff;
   logic [mlpq_pkg::OCC_W-1:0] occupancy_in;
   logic                       rsp_valid_ff;
   mlpq_pkg::rsp_type          rsp_ff;
   mlpq_pkg::rsp_type          rsp_in;

   mlpq_pkg::slot_cmd_type     cmd;
   mlpq_pkg::slot_head_type    head;

   logic [mlpq_pkg::LEVEL_W-1:0] lv;
   logic is_write;
   logic full;
   logic read_ok;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
   end

   assign lv       = mlpq_pkg::clamp_level(req_ff.level);
   assign is_write = (req_ff.opcode == mlpq_pkg::OP_APPEND) ||
                     (req_ff.opcode == mlpq_pkg::OP_FRONT);
   assign full     = occupancy_ff == mlpq_pkg::OCC_W'(mlpq_pkg::QUEUE_DEPTH);
   assign read_ok  = head.valid && (head.level <= lv);

   always_comb begin
      cmd.insert = req_valid_ff && is_write && !full;
      cmd.front  = req_ff.opcode == mlpq_pkg::OP_FRONT;
      cmd.pop    = req_valid_ff && (req_ff.opcode == mlpq_pkg::OP_READ) && read_ok;
      cmd.clear  = req_valid_ff && (req_ff.opcode == mlpq_pkg::OP_PURGE);
      cmd.level  = lv;
      cmd.data   = req_ff.payload[mlpq_pkg::DATA_WIDTH-1:0];
   end

   mlpq_slot_array u_slots (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .head  (head)
   );

   always_comb begin
      rsp_in       = '0;
      occupancy_in = occupancy_ff;
      case (req_ff.opcode)
         mlpq_pkg::OP_APPEND, mlpq_pkg::OP_FRONT: begin
            if (full) begin
               rsp_in.status = mlpq_pkg::ST_FULL;
            end else begin
               occupancy_in = occupancy_ff + mlpq_pkg::OCC_W'(1);
            end
         end
         mlpq_pkg::OP_READ: begin
            if (read_ok) begin
               rsp_in.read_payload = 32'(head.data);
               rsp_in.read_level   = head.level;
               occupancy_in        = occupancy_ff - mlpq_pkg::OCC_W'(1);
            end else begin
               rsp_in.status = mlpq_pkg::ST_EMPTY;
            end
         end
         default: begin
            rsp_in.purged_count = mlpq_pkg::COUNT_W'(occupancy_ff);
            occupancy_in        = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            occupancy_ff <= occupancy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= mlpq_pkg::OCC_W'(mlpq_pkg::QUEUE_DEPTH))
      else $error("occupancy above store depth");

   a_head_matches_occ: assert property (@(posedge clock) disable iff (reset)
      (occupancy_ff != '0) == head.valid)
      else $error("head slot disagrees with occupancy");

   a_purge_empties: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && (req_ff.opcode == mlpq_pkg::OP_PURGE) |=> occupancy_ff == '0)
      else $error("store not empty after purge");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == mlpq_pkg::ST_FULL) |->
         $past(occupancy_ff) == mlpq_pkg::OCC_W'(mlpq_pkg::QUEUE_DEPTH))
      else $error("full status with room in store");

endmodule

### rtl/mlpq_slot_array.sv
// ----------------------------------------------------------------------------
// mlpq_slot_array: ordered slot array of the priority queue
// Slots are kept in queue order with slot 0 as head. Every slot compares its
// level with the request, and the array inserts or pops by a one-slot shift.
// ----------------------------------------------------------------------------
module mlpq_slot_array (
   input  logic                    clock,
   input  logic                    reset,
   input  mlpq_pkg::slot_cmd_type  cmd,
   output mlpq_pkg::slot_head_type head
);

   localparam int DEPTH = mlpq_pkg::QUEUE_DEPTH;

   logic [DEPTH-1:0]                     valid_ff;
   logic [DEPTH-1:0]                     valid_in;
   logic [mlpq_pkg::LEVEL_W-1:0]         level_ff [DEPTH];
   logic [mlpq_pkg::LEVEL_W-1:0]         level_in [DEPTH];
   logic [mlpq_pkg::DATA_WIDTH-1:0]      data_ff  [DEPTH];
   logic [mlpq_pkg::DATA_WIDTH-1:0]      data_in  [DEPTH];

   // slot stays ahead of the new entry
   logic [DEPTH-1:0] ahead;
   logic [DEPTH-1:0] prev_ahead;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (cmd.front) begin
            ahead[i] = valid_ff[i] && (level_ff[i] < cmd.level);
         end else begin
            ahead[i] = valid_ff[i] && (level_ff[i] <= cmd.level);
         end
      end
   end

   assign prev_ahead = {ahead[DEPTH-2:0], 1'b1};

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid_in[i] = valid_ff[i];
         level_in[i] = level_ff[i];
         data_in[i]  = data_ff[i];
      end
      if (cmd.clear) begin
         valid_in = '0;
         for (int i = 0; i < DEPTH; i++) begin
            level_in[i] = '0;
         end
      end else if (cmd.insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (!ahead[i]) begin
               if (prev_ahead[i]) begin
                  valid_in[i] = 1'b1;
                  level_in[i] = cmd.level;
                  data_in[i]  = cmd.data;
               end else begin
                  // shift back by one slot
                  valid_in[i] = valid_ff[(i + DEPTH - 1) % DEPTH];
                  level_in[i] = level_ff[(i + DEPTH - 1) % DEPTH];
                  data_in[i]  = data_ff[(i + DEPTH - 1) % DEPTH];
               end
            end
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            valid_in[i] = valid_ff[i + 1];
            level_in[i] = level_ff[i + 1];
            data_in[i]  = data_ff[i + 1];
         end
         valid_in[DEPTH-1] = 1'b0;
         level_in[DEPTH-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < DEPTH; i++) begin
            level_ff[i] <= level_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         data_ff[i] <= data_in[i];
      end
   end

   assign head.valid = valid_ff[0];
   assign head.level = level_ff[0];
   assign head.data  = data_ff[0];

   // occupied slots always form a prefix
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_ff >> 1) & ~valid_ff) == '0)
      else $error("slot array has a hole");

endmodule
